/* sv/sps_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sps_pkg
// Shared sizes, codes and controller/datapath interface types for the
// slotted page row store.
// ============================================================================
package sps_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_SLOTS    = 512;
    localparam int SLOT_BYTES   = 6;
    localparam int HEADER_BYTES = 8;

    localparam int KIND_W    = 2;
    localparam int DATA_W    = 8;
    localparam int SLOTNUM_W = 9;
    localparam int INDEX_W   = 12;
    localparam int QLEN_W    = 13;
    localparam int STATUS_W  = 3;
    localparam int SIZE_W    = 13;

    localparam int ADDR_W = $clog2(PAGE_BYTES);
    localparam int OFF_W  = $clog2(PAGE_BYTES + 1);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int OVH_W  = $clog2((MAX_SLOTS + 1) * SLOT_BYTES + 1);
    localparam int SUM_W  = $clog2(PAGE_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES
                                   + (1 << QLEN_W)) + 1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_FIT    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_INVALID = 3'd1,
        STS_DELETED = 3'd2,
        STS_NO_ROOM = 3'd3,
        STS_PAST    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLOT,
        ST_PAGE
    } t_state;

    typedef enum logic [2:0] {
        RES_INSERT,
        RES_FIT,
        RES_INVALID,
        RES_DELETED,
        RES_DEL_OK,
        RES_PAST,
        RES_READ
    } t_res;

    typedef struct packed {
        logic              fits;
        logic [SIZE_W-1:0] row_size;
        logic [DATA_W-1:0] read_byte;
        logic [SLOTNUM_W-1:0] assigned_slot;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [OFF_W-1:0]  size;
        logic              used;
    } t_slot_entry;

    typedef struct packed {
        logic load;
        logic exec_insert;
        logic slot_rd;
        logic slot_clear;
        logic page_rd;
        logic out_load;
        t_res res_sel;
    } t_ctl_cmd;

    typedef struct packed {
        t_kind kind;
        logic  last;
        logic  invalid;
        logic  used;
        logic  past;
        logic  out_busy;
    } t_dp_stat;

endpackage

/* sv/sps_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// sps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sps_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// sps_ctrl
// Sequencer: steps one word at a time through execute, slot lookup and page
// read, and holds any step that has a result while the output is full.
// ============================================================================
module sps_ctrl
    import sps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_stat.kind)
                    KIND_INSERT: begin
                        if (!(i_stat.last && i_stat.out_busy)) begin
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_FIT: begin
                        if (!i_stat.out_busy) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        if (!i_stat.invalid) begin
                            n_state = ST_SLOT;
                        end else if (!i_stat.out_busy) begin
                            n_state = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SLOT: begin
                if (i_stat.used && i_stat.kind == KIND_READ && !i_stat.past) begin
                    n_state = ST_PAGE;
                end else if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAGE: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = RES_FIT;
        o_s_tready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_EXEC: begin
                unique case (i_stat.kind)
                    KIND_INSERT: begin
                        o_cmd.res_sel = RES_INSERT;
                        if (!(i_stat.last && i_stat.out_busy)) begin
                            o_cmd.exec_insert = 1'b1;
                            o_cmd.out_load    = i_stat.last;
                        end
                    end
                    KIND_FIT: begin
                        o_cmd.res_sel  = RES_FIT;
                        o_cmd.out_load = !i_stat.out_busy;
                    end
                    default: begin
                        o_cmd.res_sel = RES_INVALID;
                        if (!i_stat.invalid) begin
                            o_cmd.slot_rd = 1'b1;
                        end else begin
                            o_cmd.out_load = !i_stat.out_busy;
                        end
                    end
                endcase
            end
            ST_SLOT: begin
                if (!i_stat.used) begin
                    o_cmd.res_sel  = RES_DELETED;
                    o_cmd.out_load = !i_stat.out_busy;
                end else if (i_stat.kind == KIND_DELETE) begin
                    o_cmd.res_sel    = RES_DEL_OK;
                    o_cmd.out_load   = !i_stat.out_busy;
                    o_cmd.slot_clear = !i_stat.out_busy;
                end else if (i_stat.past) begin
                    o_cmd.res_sel  = RES_PAST;
                    o_cmd.out_load = !i_stat.out_busy;
                end else begin
                    o_cmd.page_rd = 1'b1;
                end
            end
            ST_PAGE: begin
                o_cmd.res_sel  = RES_READ;
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/sps_dp.sv */
`timescale 1ns / 1ps
// ============================================================================
// sps_dp
// Datapath: item registers, page and slot memories, free-space bookkeeping,
// room check and the output register.
// ============================================================================
module sps_dp
    import sps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_kind                  i_kind,
    input  logic [DATA_W-1:0]      i_data_byte,
    input  logic                   i_last,
    input  logic [SLOTNUM_W-1:0]   i_slot_number,
    input  logic [INDEX_W-1:0]     i_byte_index,
    input  logic [QLEN_W-1:0]      i_query_length,
    input  t_ctl_cmd               i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int SCMP_W = (CNT_W > SLOTNUM_W) ? CNT_W : SLOTNUM_W;
    localparam int ICMP_W = (OFF_W > INDEX_W) ? OFF_W : INDEX_W;

    function automatic logic room_ok(
        input logic [OFF_W-1:0] free_off,
        input logic [OVH_W-1:0] ovh,
        input logic [CNT_W-1:0] cnt,
        input logic [SUM_W-1:0] len
    );
        logic [SUM_W-1:0] need;
        need = SUM_W'(free_off) + SUM_W'(ovh) + len;
        return (cnt < CNT_W'(MAX_SLOTS)) && (need <= SUM_W'(PAGE_BYTES));
    endfunction

    t_kind                r_kind;
    logic                 r_last;
    logic [DATA_W-1:0]    r_data;
    logic [SLOTNUM_W-1:0] r_slot;
    logic [INDEX_W-1:0]   r_index;
    logic [QLEN_W-1:0]    r_qlen;

    logic [OFF_W-1:0] r_free;
    logic [OVH_W-1:0] r_ovh;
    logic [CNT_W-1:0] r_count;
    logic [OFF_W-1:0] r_pend;
    logic             r_fail;
    logic             r_out_valid;
    t_result          r_out;

    logic [OFF_W-1:0] pend_next;
    logic             byte_ok;
    logic             row_failed;
    logic             commit;
    t_slot_entry      slot_rdata;
    t_slot_entry      slot_wdata;
    logic             slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [DATA_W-1:0] page_rdata;
    logic [ADDR_W-1:0] page_waddr;
    logic [ADDR_W-1:0] page_raddr;
    t_result           res;

    assign pend_next  = r_pend + OFF_W'(1);
    assign byte_ok    = !r_fail && room_ok(r_free, r_ovh, r_count, SUM_W'(pend_next));
    assign row_failed = r_fail || !byte_ok;
    assign commit     = i_cmd.exec_insert && r_last && !row_failed;
    assign page_waddr = ADDR_W'(r_free + r_pend);
    assign page_raddr = slot_rdata.start + ADDR_W'(r_index);

    always_comb begin
        slot_we    = commit || i_cmd.slot_clear;
        slot_waddr = SLOT_W'(r_slot);
        slot_wdata = slot_rdata;
        slot_wdata.used = 1'b0;
        if (commit) begin
            slot_waddr       = SLOT_W'(r_count);
            slot_wdata.start = ADDR_W'(r_free);
            slot_wdata.size  = pend_next;
            slot_wdata.used  = 1'b1;
        end
    end

    sps_ram #(
        .WIDTH ($bits(t_slot_entry)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.slot_rd),
        .i_raddr (SLOT_W'(r_slot)),
        .o_rdata (slot_rdata)
    );

    sps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PAGE_BYTES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec_insert && byte_ok),
        .i_waddr (page_waddr),
        .i_wdata (r_data),
        .i_re    (i_cmd.page_rd),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    always_comb begin
        res = '0;
        unique case (i_cmd.res_sel)
            RES_INSERT: begin
                if (row_failed) begin
                    res.status = STS_NO_ROOM;
                end else begin
                    res.status        = STS_OK;
                    res.assigned_slot = SLOTNUM_W'(r_count);
                    res.row_size      = SIZE_W'(pend_next);
                end
            end
            RES_FIT: begin
                res.status = STS_OK;
                res.fits   = room_ok(r_free, r_ovh, r_count, SUM_W'(r_qlen));
            end
            RES_INVALID: res.status = STS_INVALID;
            RES_DELETED: res.status = STS_DELETED;
            RES_DEL_OK:  res.status = STS_OK;
            RES_PAST: begin
                res.status   = STS_PAST;
                res.row_size = SIZE_W'(slot_rdata.size);
            end
            RES_READ: begin
                res.status    = STS_OK;
                res.read_byte = page_rdata;
                res.row_size  = SIZE_W'(slot_rdata.size);
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_last  <= i_last;
            r_data  <= i_data_byte;
            r_slot  <= i_slot_number;
            r_index <= i_byte_index;
            r_qlen  <= i_query_length;
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= OFF_W'(HEADER_BYTES);
            r_ovh       <= OVH_W'(SLOT_BYTES);
            r_count     <= '0;
            r_pend      <= '0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec_insert) begin
                if (r_last) begin
                    r_pend <= '0;
                    r_fail <= 1'b0;
                    if (!row_failed) begin
                        r_free  <= r_free + pend_next;
                        r_ovh   <= r_ovh + OVH_W'(SLOT_BYTES);
                        r_count <= r_count + CNT_W'(1);
                    end
                end else if (byte_ok) begin
                    r_pend <= pend_next;
                end else begin
                    r_fail <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.last     = r_last;
    assign o_stat.invalid  = SCMP_W'(r_slot) >= SCMP_W'(r_count);
    assign o_stat.used     = slot_rdata.used;
    assign o_stat.past     = ICMP_W'(r_index) >= ICMP_W'(slot_rdata.size);
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef NO_ASSERTIONS
    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_free) + SUM_W'(r_ovh) <= SUM_W'(PAGE_BYTES + SLOT_BYTES))
        else $error("committed rows overrun the slot table");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("slot count past table size");
    a_ovh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovh == OVH_W'((32'(r_count) + 32'd1) * SLOT_BYTES))
        else $error("slot overhead out of step with slot count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_m_tready))
        else $error("result loaded over a word not yet taken");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> !i_cmd.exec_insert)
        else $error("insert executed twice for one word");
`endif

endmodule

/* sv/slotted_page_row_store.sv */
`timescale 1ns / 1ps
// ============================================================================
// slotted_page_row_store
// Slotted page: rows appended upward from the header, slot table downward;
// insert byte by byte, delete, read one byte, and fit query.
// ============================================================================
// channel  dir  tdata (low bit up)                               tuser  tlast
// s        in   data_byte, slot_number, byte_index, query_length kind   last
// m        out  status, assigned_slot, read_byte, row_size, fits -      -
//
// One word at a time: insert byte, fit query and a delete or read of a slot
// at or past the slot count end in the execute step; otherwise delete, read
// of a deleted slot and read past the row add a slot RAM read, and a read
// that fetches its byte adds a slot RAM read, then a page RAM read.
// Reset is synchronous; both RAMs are left uncleared and the block is ready
// right after reset. A result waits in the output register; a later step that
// has a result holds until that register is taken.
// ============================================================================
module slotted_page_row_store
    import sps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // data_byte, slot_number, byte_index, query_length
    input  logic [KIND_W-1:0]      i_s_tuser,  // kind
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata   // status, assigned_slot, read_byte, row_size, fits
);

    localparam int SLOT_LSB  = DATA_W;
    localparam int INDEX_LSB = SLOT_LSB + SLOTNUM_W;
    localparam int QLEN_LSB  = INDEX_LSB + INDEX_W;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (t_kind'(i_s_tuser)),
        .i_data_byte    (i_s_tdata[DATA_W-1:0]),
        .i_last         (i_s_tlast),
        .i_slot_number  (i_s_tdata[SLOT_LSB +: SLOTNUM_W]),
        .i_byte_index   (i_s_tdata[INDEX_LSB +: INDEX_W]),
        .i_query_length (i_s_tdata[QLEN_LSB +: QLEN_W]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_m_tdata      (o_m_tdata)
    );

endmodule
